[rtl/core/hsv_saturation_scaler_assert.svh]
// Assertion macros used by the saturation scaler RTL.
`ifndef HSV_SATURATION_SCALER_ASSERT_SVH
`define HSV_SATURATION_SCALER_ASSERT_SVH

// Checks a property on every rising clock edge, idle while reset is asserted.
`define HSS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checks a property that must hold in the same cycle as its trigger.
`define HSS_ASSERT_IMP(label, trig, cond, msg) \
	`HSS_ASSERT(label, (trig) |-> (cond), msg)

`endif

[rtl/core/hss_pkg.sv]
// Package with widths, constants and payload types of the saturation scaler.
package hss_pkg;
	localparam int CHANNEL_BITS = 8;
	localparam int GAIN_BITS = 10;
	localparam int FRAC_BITS = 16;
	localparam int NUM_BITS = CHANNEL_BITS + 3;
	localparam int QUO_BITS = FRAC_BITS + 3;
	localparam int SAT_BITS = FRAC_BITS + 1;
	localparam logic [SAT_BITS-1:0] SAT_ONE = SAT_BITS'(1) << FRAC_BITS;
	localparam logic [2:0] SECTOR_LAST = 3'd5;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] in_red;
		logic [CHANNEL_BITS-1:0] in_green;
		logic [CHANNEL_BITS-1:0] in_blue;
		logic [CHANNEL_BITS-1:0] in_alpha;
		logic [GAIN_BITS-1:0] sat_gain;
	} pix_in_t;

	typedef struct packed {
		logic [CHANNEL_BITS-1:0] out_red;
		logic [CHANNEL_BITS-1:0] out_green;
		logic [CHANNEL_BITS-1:0] out_blue;
		logic [CHANNEL_BITS-1:0] out_alpha;
	} pix_out_t;

	// Values that ride alongside the two dividers.
	typedef struct packed {
		logic [CHANNEL_BITS-1:0] v;
		logic [GAIN_BITS-1:0] gain;
		logic [CHANNEL_BITS-1:0] alpha;
		logic gray;
	} side_t;
endpackage

[rtl/core/hss_divider.sv]
// Pipelined restoring divider: (num * 2^16) / den, one quotient bit per stage.
module hss_divider import hss_pkg::*; (
	input  logic clk,
	input  logic en,
	input  logic [NUM_BITS-1:0] num,
	input  logic [CHANNEL_BITS-1:0] den,
	output logic [QUO_BITS-1:0] quo
);
	logic [CHANNEL_BITS-1:0] rem_s [0:QUO_BITS];
	logic [CHANNEL_BITS-1:0] den_s [0:QUO_BITS];
	logic [QUO_BITS-1:0] bits_s [0:QUO_BITS];
	logic [QUO_BITS-1:0] quo_s [0:QUO_BITS];

	// The top bits of the numerator are already below the divisor.
	assign rem_s[0] = num[NUM_BITS-1:3];
	assign den_s[0] = den;
	assign bits_s[0] = {num[2:0], {FRAC_BITS{1'b0}}};
	assign quo_s[0] = '0;

	for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
		logic [CHANNEL_BITS:0] trial;
		logic [CHANNEL_BITS:0] diff;
		logic ge;
		assign trial = {rem_s[i], bits_s[i][QUO_BITS-1]};
		assign ge = trial >= {1'b0, den_s[i]};
		assign diff = trial - {1'b0, den_s[i]};
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[i+1] <= ge ? diff[CHANNEL_BITS-1:0] : trial[CHANNEL_BITS-1:0];
				den_s[i+1] <= den_s[i];
				bits_s[i+1] <= {bits_s[i][QUO_BITS-2:0], 1'b0};
				quo_s[i+1] <= {quo_s[i][QUO_BITS-2:0], ge};
			end
		end
	end

	assign quo = quo_s[QUO_BITS];
endmodule

[rtl/core/hsv_saturation_scaler.sv]
// Saturation scaler top level: RGB to HSV, saturation gain, HSV back to RGB.
// The block takes one pixel every clock unless a stall holds it; it has one input
// stage, 19 stages of the two pipelined hue and saturation dividers (one quotient
// bit each), three multiply stages and the output register. A result-side stall
// with a pixel waiting freezes the whole pipeline; alpha rides along unchanged
// and a gray pixel leaves with all three channels equal to its largest channel.
`include "hsv_saturation_scaler_assert.svh"
module hsv_saturation_scaler import hss_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic src_valid,
	output logic src_stall,
	input  pix_in_t src_pix,
	output logic dst_valid,
	input  logic dst_stall,
	output pix_out_t dst_pix
);
	localparam int CB = CHANNEL_BITS;
	localparam int CQW = CB + SAT_BITS;

	logic adv;
	assign adv = !(dst_valid && dst_stall);
	assign src_stall = !adv;

	// Stage 1: value, delta and hue numerator.
	logic [CB-1:0] r, g, b, vmax, vmin, delta;
	logic [NUM_BITS-1:0] d_ext, hnum;
	always_comb begin
		r = src_pix.in_red;
		g = src_pix.in_green;
		b = src_pix.in_blue;
		vmax = r;
		if (g > vmax) vmax = g;
		if (b > vmax) vmax = b;
		vmin = r;
		if (g < vmin) vmin = g;
		if (b < vmin) vmin = b;
		delta = vmax - vmin;
		d_ext = NUM_BITS'(delta);
		// Modular arithmetic is fine here: the true result is never negative.
		priority if (vmax == r) begin
			if (g >= b) hnum = NUM_BITS'(g) - NUM_BITS'(b);
			else hnum = NUM_BITS'(6) * d_ext - (NUM_BITS'(b) - NUM_BITS'(g));
		end else if (vmax == g) begin
			hnum = NUM_BITS'(2) * d_ext + NUM_BITS'(b) - NUM_BITS'(r);
		end else begin
			hnum = NUM_BITS'(4) * d_ext + NUM_BITS'(r) - NUM_BITS'(g);
		end
	end

	logic vld_s1;
	logic [CB-1:0] delta_s1;
	logic [NUM_BITS-1:0] hnum_s1;
	side_t side_s1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else if (adv) vld_s1 <= src_valid;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			delta_s1 <= delta;
			hnum_s1 <= hnum;
			side_s1 <= '{v: vmax, gain: src_pix.sat_gain, alpha: src_pix.in_alpha,
				gray: (delta == '0)};
		end
	end

	// Divider stages.
	logic [QUO_BITS-1:0] sat_quo, hue_quo;
	hss_divider u_sat_div (.clk, .en(adv), .num(NUM_BITS'(delta_s1)), .den(side_s1.v),
		.quo(sat_quo));
	hss_divider u_hue_div (.clk, .en(adv), .num(hnum_s1), .den(delta_s1), .quo(hue_quo));

	logic vld_d [1:QUO_BITS];
	side_t side_d [1:QUO_BITS];
	for (genvar i = 1; i <= QUO_BITS; i++) begin : g_side
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) vld_d[i] <= 1'b0;
			else if (adv) vld_d[i] <= (i == 1) ? vld_s1 : vld_d[i == 1 ? 1 : i-1];
		end
		always_ff @(posedge clk) begin
			if (adv) side_d[i] <= (i == 1) ? side_s1 : side_d[i == 1 ? 1 : i-1];
		end
	end

	// Stage A: scaled saturation and hue sector.
	logic [SAT_BITS+GAIN_BITS-1:0] sat_prod;
	logic [SAT_BITS+GAIN_BITS-9:0] sat_scaled;
	assign sat_prod = sat_quo[SAT_BITS-1:0] * side_d[QUO_BITS].gain;
	assign sat_scaled = sat_prod[SAT_BITS+GAIN_BITS-1:8];

	logic vld_sa;
	logic [SAT_BITS-1:0] sat_sa;
	logic [2:0] sector_sa;
	logic [FRAC_BITS-1:0] frac_sa;
	side_t side_sa;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sa <= 1'b0;
		else if (adv) vld_sa <= vld_d[QUO_BITS];
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			sat_sa <= (sat_scaled > (SAT_BITS+GAIN_BITS-8)'(SAT_ONE)) ? SAT_ONE
				: sat_scaled[SAT_BITS-1:0];
			sector_sa <= hue_quo[QUO_BITS-1:FRAC_BITS];
			frac_sa <= hue_quo[FRAC_BITS-1:0];
			side_sa <= side_d[QUO_BITS];
		end
	end

	// Stage B: chroma and the ramp weight of the sector.
	logic vld_sb;
	logic [CQW-1:0] cq_sb;
	logic [SAT_BITS-1:0] wt_sb;
	logic [2:0] sector_sb;
	side_t side_sb;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sb <= 1'b0;
		else if (adv) vld_sb <= vld_sa;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			cq_sb <= side_sa.v * sat_sa;
			wt_sb <= sector_sa[0] ? (SAT_ONE - {1'b0, frac_sa}) : {1'b0, frac_sa};
			sector_sb <= sector_sa;
			side_sb <= side_sa;
		end
	end

	// Stage C: second component and the common offset m.
	logic [CQW+SAT_BITS-1:0] x_prod;
	logic [CQW-1:0] m_full;
	assign x_prod = cq_sb * wt_sb;
	assign m_full = {1'b0, side_sb.v, {FRAC_BITS{1'b0}}} - cq_sb;

	logic vld_sc;
	logic [CQW-1:0] xq_sc;
	logic [CB+FRAC_BITS-1:0] m_sc;
	logic [2:0] sector_sc;
	side_t side_sc;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_sc <= 1'b0;
		else if (adv) vld_sc <= vld_sb;
	end
	always_ff @(posedge clk) begin
		if (adv) begin
			xq_sc <= x_prod[CQW+FRAC_BITS-1:FRAC_BITS];
			m_sc <= m_full[CB+FRAC_BITS-1:0];
			sector_sc <= sector_sb;
			side_sc <= side_sb;
		end
	end

	// Output stage: place the components by sector, or the value in all three if gray.
	logic [CQW-1:0] x_sum;
	logic [CB-1:0] cc, xx, zz;
	pix_out_t pix_next;
	assign x_sum = xq_sc + CQW'(m_sc);
	assign cc = side_sc.v;
	assign xx = x_sum[CB+FRAC_BITS-1:FRAC_BITS];
	assign zz = m_sc[CB+FRAC_BITS-1:FRAC_BITS];
	always_comb begin
		pix_next.out_alpha = side_sc.alpha;
		unique case (sector_sc)
			3'd0: {pix_next.out_red, pix_next.out_green, pix_next.out_blue} = {cc, xx, zz};
			3'd1: {pix_next.out_red, pix_next.out_green, pix_next.out_blue} = {xx, cc, zz};
			3'd2: {pix_next.out_red, pix_next.out_green, pix_next.out_blue} = {zz, cc, xx};
			3'd3: {pix_next.out_red, pix_next.out_green, pix_next.out_blue} = {zz, xx, cc};
			3'd4: {pix_next.out_red, pix_next.out_green, pix_next.out_blue} = {xx, zz, cc};
			default: {pix_next.out_red, pix_next.out_green, pix_next.out_blue} = {cc, zz, xx};
		endcase
		if (side_sc.gray) begin
			pix_next.out_red = cc;
			pix_next.out_green = cc;
			pix_next.out_blue = cc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dst_valid <= 1'b0;
		else if (adv) dst_valid <= vld_sc;
	end
	always_ff @(posedge clk) begin
		if (adv) dst_pix <= pix_next;
	end

	`HSS_ASSERT(a_out_follows_pipe, adv |=> (dst_valid == $past(vld_sc)), "output valid lost")
	`HSS_ASSERT_IMP(a_sat_clamped, vld_sa, sat_sa <= SAT_ONE, "saturation above one")
	`HSS_ASSERT_IMP(a_sector_range, vld_sc && !side_sc.gray, sector_sc <= SECTOR_LAST, "bad sector")
endmodule

[tb/sv/hsv_saturation_scaler_tb.sv]
// Self-checking testbench for the HSV saturation scaler with a bit-exact pixel predictor.
module hsv_saturation_scaler_tb import hss_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 24;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int IN_BITS = $bits(pix_in_t);

	logic clk;
	logic arst_n;
	logic src_valid;
	logic src_stall;
	pix_in_t src_pix;
	logic dst_valid;
	logic dst_stall;
	pix_out_t dst_pix;

	pix_out_t expected_pixels[$];
	int mismatches;
	int pixels_sent;
	int pixels_checked;
	int idle_cycles;
	bit hold_dst;
	bit timed_out;

	hsv_saturation_scaler dut (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(src_valid),
		.src_stall(src_stall),
		.src_pix(src_pix),
		.dst_valid(dst_valid),
		.dst_stall(dst_stall),
		.dst_pix(dst_pix)
	);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// Fixed-point saturation change of one pixel.
	function automatic pix_out_t scale_saturation(pix_in_t p);
		pix_out_t o;
		longint unsigned r, g, b, v, mn, delta, s, num, h, f, cq, xq, m, cc, xx, zz;
		int unsigned sector;
		r = 64'(p.in_red);
		g = 64'(p.in_green);
		b = 64'(p.in_blue);
		v = r;
		if (g > v) v = g;
		if (b > v) v = b;
		mn = r;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		delta = v - mn;
		o.out_alpha = p.in_alpha;
		if (delta == 0) begin
			o.out_red = v[7:0];
			o.out_green = v[7:0];
			o.out_blue = v[7:0];
			return o;
		end
		s = (delta << 16) / v;
		s = (s * 64'(p.sat_gain)) >> 8;
		if (s > 65536) s = 65536;
		if (v == r) begin
			if (g >= b) num = g - b;
			else num = 6 * delta - (b - g);
		end else if (v == g) begin
			num = 2 * delta + b - r;
		end else begin
			num = 4 * delta + r - g;
		end
		h = (num << 16) / delta;
		sector = 32'(h >> 16);
		f = h & 64'hFFFF;
		cq = v * s;
		m = (v << 16) - cq;
		if (sector % 2 == 1) xq = (cq * (65536 - f)) >> 16;
		else xq = (cq * f) >> 16;
		cc = ((cq + m) >> 16) & 64'hFF;
		xx = ((xq + m) >> 16) & 64'hFF;
		zz = (m >> 16) & 64'hFF;
		case (sector)
			0: begin o.out_red = cc[7:0]; o.out_green = xx[7:0]; o.out_blue = zz[7:0]; end
			1: begin o.out_red = xx[7:0]; o.out_green = cc[7:0]; o.out_blue = zz[7:0]; end
			2: begin o.out_red = zz[7:0]; o.out_green = cc[7:0]; o.out_blue = xx[7:0]; end
			3: begin o.out_red = zz[7:0]; o.out_green = xx[7:0]; o.out_blue = cc[7:0]; end
			4: begin o.out_red = xx[7:0]; o.out_green = zz[7:0]; o.out_blue = cc[7:0]; end
			default: begin o.out_red = cc[7:0]; o.out_green = zz[7:0]; o.out_blue = xx[7:0]; end
		endcase
		return o;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		$display("ERROR: pixel %0d %s got %0d expected %0d", pixels_checked, what, got, want);
		mismatches++;
	endtask

	function automatic int gap_length();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60) return 0;
		if (pick < 95) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	// Offers one pixel and waits until the transaction is accepted. Valid stays up
	// afterwards so that the next pixel can follow in the very next cycle.
	task automatic send_pixel(pix_in_t p, bit with_gaps);
		int gap;
		gap = with_gaps ? gap_length() : 0;
		if (gap > 0) begin
			src_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_pix <= p;
		do @(posedge clk); while (src_stall);
		expected_pixels.push_back(scale_saturation(p));
		pixels_sent++;
	endtask

	task automatic wait_drained();
		src_valid <= 1'b0;
		while (expected_pixels.size() != 0 && !timed_out) @(posedge clk);
	endtask

	function automatic pix_in_t make_pixel(int r, int g, int b, int a, int gain);
		pix_in_t p;
		p.in_red = 8'(r);
		p.in_green = 8'(g);
		p.in_blue = 8'(b);
		p.in_alpha = 8'(a);
		p.sat_gain = 10'(gain);
		return p;
	endfunction

	// Corners: gray and black, channel ties, every hue sector, gain extremes.
	task automatic test_directed();
		send_pixel(make_pixel(0, 0, 0, 0, 0), 1'b0);
		send_pixel(make_pixel(255, 255, 255, 255, 1023), 1'b0);
		send_pixel(make_pixel(128, 128, 128, 7, 512), 1'b0);
		send_pixel(make_pixel(255, 0, 0, 255, 256), 1'b0);
		send_pixel(make_pixel(255, 128, 0, 1, 128), 1'b0);
		send_pixel(make_pixel(128, 255, 0, 2, 300), 1'b0);
		send_pixel(make_pixel(0, 255, 128, 3, 700), 1'b0);
		send_pixel(make_pixel(0, 128, 255, 4, 1023), 1'b0);
		send_pixel(make_pixel(128, 0, 255, 5, 0), 1'b0);
		send_pixel(make_pixel(255, 0, 128, 6, 1), 1'b0);
		send_pixel(make_pixel(200, 200, 10, 8, 256), 1'b0);
		send_pixel(make_pixel(10, 200, 200, 9, 256), 1'b0);
		send_pixel(make_pixel(200, 10, 200, 10, 256), 1'b0);
		send_pixel(make_pixel(1, 0, 0, 170, 1023), 1'b0);
		send_pixel(make_pixel(255, 254, 254, 85, 1023), 1'b0);
		send_pixel(make_pixel(0, 1, 255, 255, 255), 1'b0);
		wait_drained();
	endtask

	task automatic test_random(int count);
		pix_in_t p;
		for (int i = 0; i < count; i++) begin
			p = pix_in_t'(IN_BITS'({$urandom, $urandom}));
			if ($urandom_range(0, 9) == 0) begin
				p.in_green = p.in_red;
				p.in_blue = p.in_red;
			end
			send_pixel(p, 1'b1);
		end
	endtask

	// The result side holds off while the sender keeps offering pixels.
	task automatic test_backpressure();
		hold_dst = 1'b1;
		fork
			begin
				repeat (3 * LATENCY) @(posedge clk);
				hold_dst = 1'b0;
			end
			for (int i = 0; i < 60; i++)
				send_pixel(pix_in_t'(IN_BITS'({$urandom, $urandom})), 1'b0);
		join
		wait_drained();
	endtask

	// Random stall on the result side, with stretches of none.
	always @(posedge clk) begin
		if (!arst_n) begin
			dst_stall <= 1'b0;
		end else if (hold_dst) begin
			dst_stall <= 1'b1;
		end else if ((pixels_sent / 200) % 2 == 1) begin
			dst_stall <= 1'b0;
		end else begin
			dst_stall <= ($urandom_range(0, 99) < 25);
		end
	end

	always @(posedge clk) begin
		if (arst_n && dst_valid && !dst_stall) begin
			if (expected_pixels.size() == 0) begin
				report_mismatch("result with no pixel outstanding, valid", 1, 0);
			end else begin
				pix_out_t want;
				want = expected_pixels.pop_front();
				if (dst_pix.out_red !== want.out_red)
					report_mismatch("red", int'(dst_pix.out_red), int'(want.out_red));
				if (dst_pix.out_green !== want.out_green)
					report_mismatch("green", int'(dst_pix.out_green), int'(want.out_green));
				if (dst_pix.out_blue !== want.out_blue)
					report_mismatch("blue", int'(dst_pix.out_blue), int'(want.out_blue));
				if (dst_pix.out_alpha !== want.out_alpha)
					report_mismatch("alpha", int'(dst_pix.out_alpha), int'(want.out_alpha));
			end
			pixels_checked++;
		end
	end

	// Counts cycles without any transaction.
	always @(posedge clk) begin
		if ((src_valid && !src_stall) || (dst_valid && !dst_stall) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles == WATCHDOG_LIMIT) begin
			timed_out = 1'b1;
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		src_valid = 1'b0;
		src_pix = '0;
		hold_dst = 1'b0;
		timed_out = 1'b0;
		mismatches = 0;
		pixels_sent = 0;
		pixels_checked = 0;
		idle_cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(450);
		test_backpressure();
		wait_drained();
		test_random(500);
		wait_drained();
		repeat (LATENCY + 4) @(posedge clk);
		$display("Sent %0d pixels and checked %0d results, covering gray, ties, all hue",
			pixels_sent, pixels_checked);
		$display("sectors, gain extremes and a long stall on the result side.");
		if (mismatches == 0 && expected_pixels.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end
endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/hss_pkg.sv
rtl/core/hss_divider.sv
rtl/core/hsv_saturation_scaler.sv
tb/sv/hsv_saturation_scaler_tb.sv
